>>> design/htfd_pkg.sv
`default_nettype none

package htfd_pkg;

  localparam logic [7:0] CRC_INIT = 8'hFF;
  localparam logic [7:0] CRC_POLY = 8'h31;

  // Full-scale spans and offsets in hundredths
  localparam logic [14:0] TEMP_SCALE  = 15'd17500;
  localparam logic [14:0] TEMP_OFFSET = 15'd4500;
  localparam logic [13:0] HUM_SCALE   = 14'd12500;
  localparam logic [13:0] HUM_OFFSET  = 14'd600;
  localparam logic [13:0] HUM_MAX     = 14'd10000;
  localparam logic [13:0] HUM_CEIL    = 14'd10600;

  typedef enum logic [2:0] {
    POS_TEMP_HI  = 3'd0,
    POS_TEMP_LO  = 3'd1,
    POS_TEMP_CRC = 3'd2,
    POS_HUM_HI   = 3'd3,
    POS_HUM_LO   = 3'd4,
    POS_HUM_CRC  = 3'd5
  } htfd_pos_t;

  typedef struct packed {
    logic        crc_err;
    logic [15:0] temp_raw;
    logic [15:0] humid_raw;
  } htfd_frame_t;

  // CRC-8, MSB first, one byte unrolled
  function automatic logic [7:0] crc8_feed(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

endpackage

`default_nettype wire

>>> design/htfd_conv.sv
`default_nettype none

module htfd_conv (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  frm_valid,
  output logic                  frm_ready,
  input  htfd_pkg::htfd_frame_t frm,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [63:0]           out_tdata
);
  import htfd_pkg::*;

  logic        a_valid_r;
  htfd_frame_t a_frm_r;
  logic [30:0] a_tprod_r;
  logic [29:0] a_hprod_r;
  logic [30:0] tprod;
  logic [29:0] hprod;

  logic        out_valid_r;
  logic [63:0] out_data_r;
  logic [63:0] out_data_nxt;

  logic        a_en;
  logic        b_en;

  logic [31:0] tsum;
  logic [30:0] hsum;
  logic [14:0] tq;
  logic [13:0] hq;
  logic [14:0] temp_centi;
  logic [13:0] humid_centi;

  assign b_en      = !out_valid_r || out_tready;
  assign a_en      = !a_valid_r || b_en;
  assign frm_ready = a_en;

  assign tprod = 31'(frm.temp_raw) * 31'(TEMP_SCALE);
  assign hprod = 30'(frm.humid_raw) * 30'(HUM_SCALE);

  // floor(x / 65535) as (x + (x >> 16) + 1) >> 16, exact for quotients below 65536
  always_comb begin
    tsum = 32'(a_tprod_r) + 32'(a_tprod_r[30:16]) + 32'd1;
    hsum = 31'(a_hprod_r) + 31'(a_hprod_r[29:16]) + 31'd1;
    tq   = tsum[30:16];
    hq   = hsum[29:16];

    temp_centi = tq - TEMP_OFFSET;
    if (hq < HUM_OFFSET) begin
      humid_centi = '0;
    end else if (hq > HUM_CEIL) begin
      humid_centi = HUM_MAX;
    end else begin
      humid_centi = hq - HUM_OFFSET;
    end

    if (a_frm_r.crc_err) begin
      temp_centi  = '0;
      humid_centi = '0;
    end

    out_data_nxt = {2'b00, a_frm_r.humid_raw, a_frm_r.temp_raw, humid_centi, temp_centi,
                    a_frm_r.crc_err};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (a_en) begin
        a_valid_r <= frm_valid;
      end
      if (b_en) begin
        out_valid_r <= a_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_en && frm_valid) begin
      a_frm_r   <= frm;
      a_tprod_r <= tprod;
      a_hprod_r <= hprod;
    end
    if (b_en && a_valid_r) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire

>>> design/humidity_temp_frame_decoder.sv
// Throughput: one reply byte per cycle, except that the sixth byte waits while the conversion
// stage cannot take a frame; one result per six bytes. After the transfer of the sixth byte the
// result passes one register after the scaling multipliers, then one output register.
// Reset: frame position returns to the first temperature byte, running CRC to 0xFF,
// stored words to zero, and the conversion pipeline empties.
`default_nettype none

module humidity_temp_frame_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata   // [0] status, [15:1] temp_centi, [29:16] humid_centi,
                                  // [45:30] raw_temp_word, [61:46] raw_humid_word, [63:62] zero
);
  import htfd_pkg::*;

  htfd_pos_t   pos_r, pos_nxt;
  logic [7:0]  crc_r, crc_nxt;
  logic [15:0] temp_word_r, temp_word_nxt;
  logic [7:0]  humid_high_r, humid_high_nxt;
  logic [7:0]  humid_low_r, humid_low_nxt;
  logic        temp_good_r, temp_good_nxt;

  logic        in_xfer;
  logic        is_last;
  logic        frm_valid;
  logic        frm_ready;
  htfd_frame_t frm;

  assign is_last = (pos_r == POS_HUM_CRC);
  assign in_xfer = in_tvalid && in_tready;

  // Next position; an unused code restarts the frame
  always_comb begin
    pos_nxt = pos_r;
    if (in_xfer) begin
      case (pos_r)
        POS_TEMP_HI:  pos_nxt = POS_TEMP_LO;
        POS_TEMP_LO:  pos_nxt = POS_TEMP_CRC;
        POS_TEMP_CRC: pos_nxt = POS_HUM_HI;
        POS_HUM_HI:   pos_nxt = POS_HUM_LO;
        POS_HUM_LO:   pos_nxt = POS_HUM_CRC;
        POS_HUM_CRC:  pos_nxt = POS_TEMP_HI;
        default:      pos_nxt = POS_TEMP_LO;
      endcase
    end
  end

  always_comb begin
    crc_nxt        = crc_r;
    temp_word_nxt  = temp_word_r;
    humid_high_nxt = humid_high_r;
    humid_low_nxt  = humid_low_r;
    temp_good_nxt  = temp_good_r;

    in_tready = !is_last || frm_ready;

    if (in_xfer) begin
      case (pos_r)
        POS_TEMP_LO: begin
          temp_word_nxt[7:0] = in_tdata;
          crc_nxt            = crc8_feed(crc_r, in_tdata);
        end
        POS_TEMP_CRC: begin
          temp_good_nxt = (crc_r == in_tdata);
          crc_nxt       = CRC_INIT;
        end
        POS_HUM_HI: begin
          humid_high_nxt = in_tdata;
          crc_nxt        = crc8_feed(crc_r, in_tdata);
        end
        POS_HUM_LO: begin
          humid_low_nxt = in_tdata;
          crc_nxt       = crc8_feed(crc_r, in_tdata);
        end
        POS_HUM_CRC: begin
          crc_nxt = CRC_INIT;
        end
        default: begin
          temp_word_nxt[15:8] = in_tdata;
          crc_nxt             = crc8_feed(crc_r, in_tdata);
        end
      endcase
    end

    // Hand the finished frame to conversion on the last byte
    frm_valid     = in_tvalid && is_last;
    frm.crc_err   = !(temp_good_r && (crc_r == in_tdata));
    frm.temp_raw  = temp_word_r;
    frm.humid_raw = {humid_high_r, humid_low_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r        <= POS_TEMP_HI;
      crc_r        <= CRC_INIT;
      temp_word_r  <= '0;
      humid_high_r <= '0;
      humid_low_r  <= '0;
      temp_good_r  <= 1'b0;
    end else begin
      pos_r        <= pos_nxt;
      crc_r        <= crc_nxt;
      temp_word_r  <= temp_word_nxt;
      humid_high_r <= humid_high_nxt;
      humid_low_r  <= humid_low_nxt;
      temp_good_r  <= temp_good_nxt;
    end
  end

  htfd_conv u_conv (
    .clk        (clk),
    .rst_n      (rst_n),
    .frm_valid  (frm_valid),
    .frm_ready  (frm_ready),
    .frm        (frm),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

`default_nettype wire

>>> design/htfd_checker.sv
`default_nettype none

module htfd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [63:0] out_tdata
);

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // CRC error zeroes both converted values
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[0] |-> out_tdata[29:1] == 29'd0)
    else $error("converted values not zero on CRC error");

  // Humidity stays within its clamp
  a_hum_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] |-> out_tdata[29:16] <= 14'd10000)
    else $error("humidity beyond clamp");

  // Temperature never below the sensor floor
  a_temp_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] |-> $signed(out_tdata[15:1]) >= -15'sd4500)
    else $error("temperature below floor");

endmodule

bind humidity_temp_frame_decoder htfd_checker u_htfd_checker (.*);

`default_nettype wire
